// ===== design/trace_mix_cycle_footprint_counter_defines.svh =====
// assertion macros used by the profiler checker
`ifndef TRACE_MIX_CYCLE_FOOTPRINT_COUNTER_DEFINES_SVH
`define TRACE_MIX_CYCLE_FOOTPRINT_COUNTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TMCFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define TMCFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tmcfc_pkg.sv =====
// constants, types and reset values for the profiler
package tmcfc_pkg;

  localparam int unsigned TYPE_COUNT    = 8;
  localparam int unsigned PC_ENTRIES    = 1024;
  localparam int unsigned TYPE_IW       = $clog2(TYPE_COUNT);
  localparam int unsigned PC_IW         = $clog2(PC_ENTRIES);
  localparam int unsigned FILL_W        = $clog2(PC_ENTRIES + 1);
  localparam int unsigned OP_W          = 3;
  localparam int unsigned PC_W          = 64;
  localparam int unsigned CNT_W         = 64;
  localparam int unsigned UNIQ_W        = 11;
  localparam int unsigned COST_W        = 4;
  localparam int unsigned NUM_COST_REGS = 5;
  localparam int unsigned CFG_IDX_W     = 3;

  localparam logic [COST_W-1:0] COST_RESET [NUM_COST_REGS] = '{
    4'd1, 4'd2, 4'd2, 4'd3, 4'd1
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CNT,
    ST_SEARCH,
    ST_RESP
  } state_t;

endpackage

// ===== design/tmcfc_if.sv =====
// handshake channels: input record, result and configuration write
interface tmcfc_in_if import tmcfc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op_type;
  logic [PC_W-1:0] pc;

  modport source (output valid, output op_type, output pc, input ready);
  modport sink   (input valid, input op_type, input pc, output ready);
endinterface

interface tmcfc_out_if import tmcfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  type_count;
  logic [CNT_W-1:0]  cycle_total;
  logic [UNIQ_W-1:0] unique_count;
  logic              first_seen;
  logic              table_full;

  modport source (output valid, output type_count, output cycle_total, output unique_count,
                  output first_seen, output table_full, input ready);
  modport sink   (input valid, input type_count, input cycle_total, input unique_count,
                  input first_seen, input table_full, output ready);
endinterface

interface tmcfc_cfg_if import tmcfc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COST_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/tmcfc_ram.sv =====
// simple dual-port ram, one write and one registered read per cycle
module tmcfc_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/trace_mix_cycle_footprint_counter.sv =====
// instruction mix, cycle estimate and unique pc profiler, top level
// flow: accept in idle, then the count update, a pc table scan and a response state before result valid
//   (the scan compares one entry per cycle up to a hit or the fill level; the response waits for a free output)
// one item at a time: the input is ready again only once the result is registered
// reset: counters, fill level and cost registers take their reset values at once;
//   type counts read as zero through per-entry valid bits, no clearing pass
module trace_mix_cycle_footprint_counter import tmcfc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  tmcfc_in_if.sink    in_if,
  tmcfc_out_if.source out_if,
  tmcfc_cfg_if.sink   cfg_if
);

  state_t              state_r, state_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  logic [FILL_W-1:0]   idx_r, idx_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    cycles_r, cycles_nxt;
  logic                first_r, first_nxt;
  logic                full_r, full_nxt;
  logic [TYPE_COUNT-1:0] cnt_vld_r, cnt_vld_nxt;
  logic [COST_W-1:0]   cost_r [NUM_COST_REGS];
  logic [COST_W-1:0]   cost_nxt [NUM_COST_REGS];

  logic                out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]    out_count_r, out_count_nxt;
  logic [CNT_W-1:0]    out_cycles_r, out_cycles_nxt;
  logic [UNIQ_W-1:0]   out_uniq_r, out_uniq_nxt;
  logic                out_first_r, out_first_nxt;
  logic                out_full_r, out_full_nxt;

  logic [TYPE_IW-1:0]  op_idx;
  logic                type_ok;
  logic [FILL_W-1:0]   idx_inc;

  logic                cnt_we;
  logic [CNT_W-1:0]    cnt_rdata;
  logic                pc_we;
  logic [PC_IW-1:0]    pc_raddr;
  logic [PC_W-1:0]     pc_rdata;

  assign op_idx  = TYPE_IW'(op_r);
  assign type_ok = 32'(op_r) < TYPE_COUNT;
  assign idx_inc = idx_r + 1'b1;

  // per-type dynamic counts, read at the accept edge, written back from the count state that follows
  tmcfc_ram #(
    .DEPTH (TYPE_COUNT),
    .WIDTH (CNT_W)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (op_idx),
    .wdata (cnt_nxt),
    .raddr (TYPE_IW'(in_if.op_type)),
    .rdata (cnt_rdata)
  );

  // seen pc table, filled in order, only entries below the fill level are compared
  tmcfc_ram #(
    .DEPTH (PC_ENTRIES),
    .WIDTH (PC_W)
  ) u_pc_ram (
    .clk   (clk),
    .we    (pc_we),
    .waddr (fill_r[PC_IW-1:0]),
    .wdata (pc_r),
    .raddr (pc_raddr),
    .rdata (pc_rdata)
  );

  assign in_if.ready         = (state_r == ST_IDLE);
  assign cfg_if.ready        = 1'b1;
  assign out_if.valid        = out_valid_r;
  assign out_if.type_count   = out_count_r;
  assign out_if.cycle_total  = out_cycles_r;
  assign out_if.unique_count = out_uniq_r;
  assign out_if.first_seen   = out_first_r;
  assign out_if.table_full   = out_full_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    pc_nxt         = pc_r;
    idx_nxt        = idx_r;
    fill_nxt       = fill_r;
    cnt_nxt        = cnt_r;
    cycles_nxt     = cycles_r;
    first_nxt      = first_r;
    full_nxt       = full_r;
    cnt_vld_nxt    = cnt_vld_r;
    cost_nxt       = cost_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_count_nxt  = out_count_r;
    out_cycles_nxt = out_cycles_r;
    out_uniq_nxt   = out_uniq_r;
    out_first_nxt  = out_first_r;
    out_full_nxt   = out_full_r;
    cnt_we         = 1'b0;
    pc_we          = 1'b0;
    pc_raddr       = '0;

    if (cfg_if.valid && (32'(cfg_if.index) < NUM_COST_REGS)) begin
      cost_nxt[cfg_if.index] = cfg_if.data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          op_nxt    = in_if.op_type;
          pc_nxt    = in_if.pc;
          state_nxt = ST_CNT;
        end
      end
      ST_CNT: begin
        if (type_ok) begin
          cnt_nxt             = (cnt_vld_r[op_idx] ? cnt_rdata : '0) + 1'b1;
          cnt_we              = 1'b1;
          cnt_vld_nxt[op_idx] = 1'b1;
        end else begin
          cnt_nxt = '0;
        end
        if (32'(op_r) < NUM_COST_REGS) begin
          cycles_nxt = cycles_r + CNT_W'(cost_r[op_r]);
        end
        // entry 0 is read here and compared in the first scan cycle
        idx_nxt   = '0;
        state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        pc_raddr = idx_inc[PC_IW-1:0];
        if (idx_r >= fill_r) begin
          first_nxt = 1'b1;
          if (fill_r < FILL_W'(PC_ENTRIES)) begin
            pc_we    = 1'b1;
            fill_nxt = fill_r + 1'b1;
            full_nxt = 1'b0;
          end else begin
            full_nxt = 1'b1;
          end
          state_nxt = ST_RESP;
        end else if (pc_rdata == pc_r) begin
          first_nxt = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = ST_RESP;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = cnt_r;
          out_cycles_nxt = cycles_r;
          out_uniq_nxt   = UNIQ_W'(fill_r);
          out_first_nxt  = first_r;
          out_full_nxt   = full_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      cycles_r    <= '0;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
      cost_r      <= COST_RESET;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cycles_r    <= cycles_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      out_valid_r <= out_valid_nxt;
      cost_r      <= cost_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pc_r         <= pc_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    first_r      <= first_nxt;
    full_r       <= full_nxt;
    out_count_r  <= out_count_nxt;
    out_cycles_r <= out_cycles_nxt;
    out_uniq_r   <= out_uniq_nxt;
    out_first_r  <= out_first_nxt;
    out_full_r   <= out_full_nxt;
  end

endmodule

// ===== design/tmcfc_checker.sv =====
// port-level checks for the profiler, bound to the top level
`include "trace_mix_cycle_footprint_counter_defines.svh"

module tmcfc_checker import tmcfc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CNT_W-1:0]  out_type_count,
  input logic [UNIQ_W-1:0] out_unique_count,
  input logic              out_first_seen,
  input logic              out_table_full
);

  // one item at a time: the input closes right after an accept
  `TMCFC_ASSERT_NEXT(a_in_closes, in_valid && in_ready, !in_ready, "input still open after accept")

  // a full table only ever reports against an unseen pc
  `TMCFC_ASSERT_NOW(a_full_first, out_valid && out_table_full, out_first_seen, "full without first seen")

  `TMCFC_ASSERT_NOW(a_uniq_bound, out_valid, 32'(out_unique_count) <= PC_ENTRIES, "unique count beyond table size")

  `TMCFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_type_count) && $stable(out_unique_count), "stalled result changed")

endmodule

bind trace_mix_cycle_footprint_counter tmcfc_checker u_tmcfc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_type_count   (out_if.type_count),
  .out_unique_count (out_if.unique_count),
  .out_first_seen   (out_if.first_seen),
  .out_table_full   (out_if.table_full)
);
